[rtl/acn_pkg.sv]
// Package for the accumulator node: instruction codes, the program line
// layout and the result word shared by the execute unit and the top level.
// Depends on nothing.
package acn_pkg;

	// Instruction kinds; codes 13 to 15 execute as nop.
	localparam logic [3:0] KIND_NOP = 4'd0;
	localparam logic [3:0] KIND_SWP = 4'd1;
	localparam logic [3:0] KIND_SAV = 4'd2;
	localparam logic [3:0] KIND_NEG = 4'd3;
	localparam logic [3:0] KIND_ADD = 4'd4;
	localparam logic [3:0] KIND_SUB = 4'd5;
	localparam logic [3:0] KIND_MOV = 4'd6;
	localparam logic [3:0] KIND_JMP = 4'd7;
	localparam logic [3:0] KIND_JEZ = 4'd8;
	localparam logic [3:0] KIND_JNZ = 4'd9;
	localparam logic [3:0] KIND_JGZ = 4'd10;
	localparam logic [3:0] KIND_JLZ = 4'd11;
	localparam logic [3:0] KIND_JRO = 4'd12;

	// Operand sources.
	localparam logic [2:0] SRC_ACC   = 3'd0;
	localparam logic [2:0] SRC_INPUT = 3'd1;
	localparam logic [2:0] SRC_IMM   = 3'd2;
	localparam logic [2:0] SRC_STACK = 3'd3;

	// Destinations of mov.
	localparam logic [1:0] DEST_ACC   = 2'd0;
	localparam logic [1:0] DEST_OUT   = 2'd1;
	localparam logic [1:0] DEST_STACK = 2'd2;

	// Item opcodes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// Configuration register index.
	localparam logic REG_PROGRAM_LENGTH = 1'b0;

	typedef struct packed {
		logic [3:0]  kind;
		logic [2:0]  source;
		logic [1:0]  dest;
		logic [15:0] operand;
	} prog_line_t;

	localparam int LINE_W = $bits(prog_line_t);

	typedef struct packed {
		logic        out_valid;
		logic [15:0] out_value;
		logic        input_consumed;
		logic        starved;
		logic        stack_dropped;
		logic        stack_empty_read;
		logic [3:0]  next_pc;
		logic [15:0] acc_value;
		logic [15:0] bak_value;
	} result_t;

endpackage

[rtl/acn_in_if.sv]
// Input channel of the accumulator node: valid/ready handshake carrying
// one load or step word. Depends on nothing.
interface acn_in_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [3:0]         load_address;
	logic [3:0]         instr_kind;
	logic [2:0]         instr_source;
	logic [1:0]         instr_dest;
	logic signed [15:0] instr_operand;
	logic               input_valid;
	logic signed [15:0] input_value;

	modport source (
		output valid, opcode, load_address, instr_kind, instr_source, instr_dest,
		       instr_operand, input_valid, input_value,
		input  ready
	);
	modport sink (
		input  valid, opcode, load_address, instr_kind, instr_source, instr_dest,
		       instr_operand, input_valid, input_value,
		output ready
	);
endinterface

[rtl/acn_out_if.sv]
// Output channel of the accumulator node: valid/ready handshake carrying
// one result word per accepted input word. Depends on nothing.
interface acn_out_if;
	logic               valid;
	logic               ready;
	logic               out_valid;
	logic signed [15:0] out_value;
	logic               input_consumed;
	logic               starved;
	logic               stack_dropped;
	logic               stack_empty_read;
	logic [3:0]         next_pc;
	logic signed [15:0] acc_value;
	logic signed [15:0] bak_value;

	modport source (
		output valid, out_valid, out_value, input_consumed, starved, stack_dropped,
		       stack_empty_read, next_pc, acc_value, bak_value,
		input  ready
	);
	modport sink (
		input  valid, out_valid, out_value, input_consumed, starved, stack_dropped,
		       stack_empty_read, next_pc, acc_value, bak_value,
		output ready
	);
endinterface

[rtl/acn_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read. Depends on nothing.
module acn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

[rtl/acn_exec.sv]
// Execute unit of the accumulator node: decodes one program line against
// the architectural state and gives the next state, the stack write and
// the result word. Depends on acn_pkg.
module acn_exec import acn_pkg::*; #(
	parameter int PROGRAM_DEPTH = 16,
	parameter int STACK_DEPTH = 16,
	localparam int PAW = $clog2(PROGRAM_DEPTH),
	localparam int LW  = $clog2(PROGRAM_DEPTH + 1),
	localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
	localparam int CW  = $clog2(STACK_DEPTH + 1)
) (
	input  logic        is_step,
	input  prog_line_t  line,
	input  logic        input_valid,
	input  logic [15:0] input_value,
	input  logic [15:0] acc,
	input  logic [15:0] bak,
	input  logic [PAW-1:0] pc,
	input  logic [CW-1:0]  count,
	input  logic [15:0] pop_data,
	input  logic [LW-1:0]  len_eff,
	output result_t     res,
	output logic [PAW-1:0] pc_next,
	output logic [15:0] acc_next,
	output logic [15:0] bak_next,
	output logic [CW-1:0]  count_next,
	output logic        push_we,
	output logic [SAW-1:0] push_addr,
	output logic [15:0] push_data
);

	logic [PAW:0]    pc_inc;
	logic [PAW-1:0]  seq_next;
	logic [PAW-1:0]  jump_next;
	logic [17:0]     jro_sum;
	logic [PAW-1:0]  jro_next;
	logic            uses_src;
	logic            have;
	logic [15:0]     val;
	logic [15:0]     jro_off;
	logic            starved;
	logic            consumed;
	logic            empty;
	logic            dropped;
	logic            o_valid;
	logic [15:0]     o_value;
	logic [CW-1:0]   count_mid;

	// Sequential successor and absolute jump target, both wrapped to line 0
	// when at or beyond the program length; negative targets go to line 0.
	assign pc_inc = {1'b0, pc} + (PAW+1)'(1);
	assign seq_next = (pc_inc >= (PAW+1)'(len_eff)) ? '0 : pc_inc[PAW-1:0];
	assign jump_next = (line.operand[15] || (line.operand >= 16'(len_eff))) ? '0 :
	                   line.operand[PAW-1:0];

	assign uses_src = line.kind inside {[KIND_ADD:KIND_MOV], KIND_JRO};

	always_comb begin
		have = 1'b0;
		val = '0;
		starved = 1'b0;
		consumed = 1'b0;
		empty = 1'b0;
		dropped = 1'b0;
		o_valid = 1'b0;
		o_value = '0;
		count_mid = count;
		if (is_step && uses_src) begin
			case (line.source)
				SRC_ACC: begin
					val = acc;
					have = 1'b1;
				end
				SRC_INPUT: begin
					if (input_valid) begin
						val = input_value;
						have = 1'b1;
						consumed = 1'b1;
					end else begin
						starved = 1'b1;
					end
				end
				SRC_IMM: begin
					val = line.operand;
					have = 1'b1;
				end
				SRC_STACK: begin
					if (count != '0) begin
						count_mid = count - CW'(1);
						val = pop_data;
					end else begin
						empty = 1'b1;
					end
					have = 1'b1;
				end
				default: ;
			endcase
		end

		jro_off = have ? val : 16'd0;
		jro_sum = {{(18-PAW){1'b0}}, pc} + {{2{jro_off[15]}}, jro_off};
		jro_next = (jro_sum[17] || (jro_sum >= 18'(len_eff))) ? '0 : jro_sum[PAW-1:0];

		acc_next = acc;
		bak_next = bak;
		pc_next = pc;
		push_we = 1'b0;
		push_addr = SAW'(count_mid);
		push_data = val;
		if (is_step) begin
			pc_next = seq_next;
			if (!starved) begin
				case (line.kind)
					KIND_SWP: begin
						acc_next = bak;
						bak_next = acc;
					end
					KIND_SAV: bak_next = acc;
					KIND_NEG: acc_next = 16'd0 - acc;
					KIND_ADD: if (have) acc_next = acc + val;
					KIND_SUB: if (have) acc_next = acc - val;
					KIND_MOV: begin
						case (line.dest)
							DEST_ACC: acc_next = val;
							DEST_OUT: begin
								o_valid = 1'b1;
								o_value = val;
							end
							DEST_STACK: begin
								if (32'(count_mid) < STACK_DEPTH)
									push_we = 1'b1;
								else
									dropped = 1'b1;
							end
							default: ;
						endcase
					end
					KIND_JMP: pc_next = jump_next;
					KIND_JEZ: if (acc == 16'd0) pc_next = jump_next;
					KIND_JNZ: if (acc != 16'd0) pc_next = jump_next;
					KIND_JGZ: if (!acc[15] && acc != 16'd0) pc_next = jump_next;
					KIND_JLZ: if (acc[15]) pc_next = jump_next;
					KIND_JRO: pc_next = jro_next;
					default: ;
				endcase
			end
		end
		count_next = count_mid + CW'(push_we);

		res.out_valid = o_valid;
		res.out_value = o_value;
		res.input_consumed = consumed;
		res.starved = starved;
		res.stack_dropped = dropped;
		res.stack_empty_read = empty;
		res.next_pc = 4'(pc_next);
		res.acc_value = acc_next;
		res.bak_value = bak_next;
	end

endmodule

[rtl/accumulator_node_cpu.sv]
// Top level of the accumulator node: a small accumulator processor with a
// program memory and a stack memory. Depends on acn_pkg, acn_in_if,
// acn_out_if, acn_ram and acn_exec.
//
// Use: words arrive on in_ch. A load word (opcode 0) writes one decoded
// instruction into program memory; a step word (opcode 1) executes the line
// at the program counter, using input_value as the input operand when the
// line asks for it. Every accepted word gives exactly one result word on
// out_ch, in order, carrying the flags, the next program counter and the
// accumulator and backup values after the word.
// Throughput is one word per cycle while the receiver keeps up. The program
// and stack memories are read as the word is accepted, the line executes in
// the execute stage once those reads have landed, and the result then sits in
// the output register. The loop that sets the rate runs from the program
// memory read data through the execute unit and the next program counter
// back to the program memory read address.
// When the receiver stalls, the result waits in the output register and one
// further word is held in the execute stage; in_ch.ready drops only when
// both are full and out_ch.ready is low.
// Reset clears the program counter, accumulator, backup register, stack
// count and the pipeline, and sets program_length to 1. The memories are
// not cleared: lines must be loaded before they are executed.
// The program_length register is written over the APB port at address 0,
// by the user only while the block is idle; the block does not enforce this.
module accumulator_node_cpu import acn_pkg::*; #(
	parameter int PROGRAM_DEPTH = 16,
	parameter int STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	acn_in_if.sink      in_ch,
	acn_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PAW = $clog2(PROGRAM_DEPTH);
	localparam int LW  = $clog2(PROGRAM_DEPTH + 1);
	localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW  = $clog2(STACK_DEPTH + 1);

	// Configuration register.
	logic [4:0]    len_q;
	logic [LW-1:0] len_eff;

	// Architectural state held in flip-flops.
	logic [15:0]    acc_q;
	logic [15:0]    bak_q;
	logic [PAW-1:0] pc_q;
	logic [CW-1:0]  count_q;

	// Execute stage: the accepted word waits here while its memory reads land.
	logic        valid_s1;
	logic        opcode_s1;
	logic        input_valid_s1;
	logic [15:0] input_value_s1;
	logic        fwd_s1;
	logic [15:0] fwd_data_s1;

	// Output register.
	logic    out_v_q;
	result_t out_q;

	logic           accept;
	logic           advance;
	logic           prog_we;
	logic [PAW-1:0] prog_raddr;
	logic [LINE_W-1:0] prog_rdata;
	prog_line_t     line_s1;
	prog_line_t     load_line;
	logic [CW-1:0]  count_eff;
	logic [SAW-1:0] stack_raddr;
	logic [15:0]    stack_rdata;
	logic [15:0]    pop_data;

	result_t        ex_res;
	logic [PAW-1:0] ex_pc_next;
	logic [15:0]    ex_acc_next;
	logic [15:0]    ex_bak_next;
	logic [CW-1:0]  ex_count_next;
	logic           ex_push_we;
	logic [SAW-1:0] ex_push_addr;
	logic [15:0]    ex_push_data;

	// The execute stage moves on whenever the output register is free or
	// being emptied; a new word enters whenever the stage is free or moving.
	assign advance = valid_s1 && (!out_v_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign accept = in_ch.valid && in_ch.ready;

	// Program length as used: zero counts as one, and it never exceeds the
	// memory depth.
	always_comb begin
		if (len_q == 5'd0)
			len_eff = LW'(1);
		else if (32'(len_q) > PROGRAM_DEPTH)
			len_eff = LW'(PROGRAM_DEPTH);
		else
			len_eff = LW'(len_q);
	end

	// APB port: the single register lives at word index 0.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PROGRAM_LENGTH) ? {27'd0, len_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= 5'd1;
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == REG_PROGRAM_LENGTH) begin
			len_q <= pwdata[4:0];
		end
	end

	// Program memory. A load is written as it is accepted, so a step that
	// follows in the next cycle already sees it. A step reads the line at the
	// program counter that will hold once the word ahead of it has executed,
	// which is the execute unit's next PC when that word retires this cycle.
	assign load_line.kind = in_ch.instr_kind;
	assign load_line.source = in_ch.instr_source;
	assign load_line.dest = in_ch.instr_dest;
	assign load_line.operand = in_ch.instr_operand;
	assign prog_we = accept && (in_ch.opcode == OP_LOAD) &&
	                 (32'(in_ch.load_address) < PROGRAM_DEPTH);
	assign prog_raddr = advance ? ex_pc_next : pc_q;
	assign line_s1 = prog_line_t'(prog_rdata);

	acn_ram #(
		.WIDTH (LINE_W),
		.DEPTH (PROGRAM_DEPTH)
	) u_prog_ram (
		.clk   (clk),
		.we    (prog_we),
		.waddr (PAW'(in_ch.load_address)),
		.wdata (load_line),
		.re    (accept && (in_ch.opcode == OP_STEP)),
		.raddr (prog_raddr),
		.rdata (prog_rdata)
	);

	// Stack memory. The top entry is read speculatively for every accepted
	// word, at the stack count left by the word ahead. A push by that word
	// lands on the same edge, so a hit on the read address is forwarded.
	assign count_eff = advance ? ex_count_next : count_q;
	assign stack_raddr = (count_eff == '0) ? '0 : SAW'(count_eff - CW'(1));
	assign pop_data = fwd_s1 ? fwd_data_s1 : stack_rdata;

	acn_ram #(
		.WIDTH (16),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (advance && ex_push_we),
		.waddr (ex_push_addr),
		.wdata (ex_push_data),
		.re    (accept),
		.raddr (stack_raddr),
		.rdata (stack_rdata)
	);

	acn_exec #(
		.PROGRAM_DEPTH (PROGRAM_DEPTH),
		.STACK_DEPTH   (STACK_DEPTH)
	) u_exec (
		.is_step     (opcode_s1 == OP_STEP),
		.line        (line_s1),
		.input_valid (input_valid_s1),
		.input_value (input_value_s1),
		.acc         (acc_q),
		.bak         (bak_q),
		.pc          (pc_q),
		.count       (count_q),
		.pop_data    (pop_data),
		.len_eff     (len_eff),
		.res         (ex_res),
		.pc_next     (ex_pc_next),
		.acc_next    (ex_acc_next),
		.bak_next    (ex_bak_next),
		.count_next  (ex_count_next),
		.push_we     (ex_push_we),
		.push_addr   (ex_push_addr),
		.push_data   (ex_push_data)
	);

	// Pipeline control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_v_q <= 1'b0;
			acc_q <= '0;
			bak_q <= '0;
			pc_q <= '0;
			count_q <= '0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;

			if (advance)
				out_v_q <= 1'b1;
			else if (out_ch.ready)
				out_v_q <= 1'b0;

			if (advance) begin
				acc_q <= ex_acc_next;
				bak_q <= ex_bak_next;
				pc_q <= ex_pc_next;
				count_q <= ex_count_next;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= in_ch.opcode;
			input_valid_s1 <= in_ch.input_valid;
			input_value_s1 <= in_ch.input_value;
			fwd_s1 <= advance && ex_push_we && (ex_push_addr == stack_raddr);
			fwd_data_s1 <= ex_push_data;
		end
		if (advance)
			out_q <= ex_res;
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.out_valid = out_q.out_valid;
	assign out_ch.out_value = out_q.out_value;
	assign out_ch.input_consumed = out_q.input_consumed;
	assign out_ch.starved = out_q.starved;
	assign out_ch.stack_dropped = out_q.stack_dropped;
	assign out_ch.stack_empty_read = out_q.stack_empty_read;
	assign out_ch.next_pc = out_q.next_pc;
	assign out_ch.acc_value = out_q.acc_value;
	assign out_ch.bak_value = out_q.bak_value;

endmodule

[dv/tb_accumulator_node_cpu.sv]
`timescale 1ns / 1ps
// Self-checking testbench for accumulator_node_cpu: random and directed load/step words,
// predicted in step with the stimulus and compared word by word on the result channel.
// Depends on acn_pkg, acn_in_if, acn_out_if and the block itself.
module tb_accumulator_node_cpu;
	import acn_pkg::*;

	localparam int PROG_LINES   = 16;
	localparam int STACK_WORDS  = 16;
	localparam int HOLD_CYCLES  = 60;
	localparam int CYCLE_LIMIT  = 200000;

	// Codes that the package leaves unnamed: the empty source and destination, and
	// codes beyond the defined ones, which the block must treat as harmless.
	localparam logic [2:0] SRC_NONE     = 3'd4;
	localparam logic [2:0] SRC_BOGUS    = 3'd7;
	localparam logic [1:0] DEST_NONE    = 2'd3;
	localparam logic [3:0] KIND_BOGUS   = 4'd15;

	// One word as offered on the input channel.
	typedef struct packed {
		logic        opcode;
		logic [3:0]  load_address;
		logic [3:0]  instr_kind;
		logic [2:0]  instr_source;
		logic [1:0]  instr_dest;
		logic [15:0] instr_operand;
		logic        input_valid;
		logic [15:0] input_value;
	} acn_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	// APB side of the block; only the initial block below drives these.
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	acn_in_if  in_ch();
	acn_out_if out_ch();

	// The channel signals are fed from local registers so that they hold known values
	// from the very first instant, before reset has had any effect.
	logic      in_valid_r = 1'b0;
	acn_word_t in_word_r = '0;
	logic      out_ready_r = 1'b0;

	assign in_ch.valid         = in_valid_r;
	assign in_ch.opcode        = in_word_r.opcode;
	assign in_ch.load_address  = in_word_r.load_address;
	assign in_ch.instr_kind    = in_word_r.instr_kind;
	assign in_ch.instr_source  = in_word_r.instr_source;
	assign in_ch.instr_dest    = in_word_r.instr_dest;
	assign in_ch.instr_operand = in_word_r.instr_operand;
	assign in_ch.input_valid   = in_word_r.input_valid;
	assign in_ch.input_value   = in_word_r.input_value;
	assign out_ch.ready        = out_ready_r;

	accumulator_node_cpu u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Words waiting to be offered, and the results that they are predicted to give,
	// oldest first.
	acn_word_t pending_words[$];
	result_t   expected_results[$];

	// Flow control requested by the stimulus. While steady is set neither side idles.
	// A raised hold_req keeps the receiver stalled until hold_cnt reaches HOLD_CYCLES.
	logic steady = 1'b0;
	logic hold_req = 1'b0;
	int   hold_cnt = 0;

	int issued = 0;
	int results_seen = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	// Private copy of the machine: program and stack memories, the registers and the
	// program length as last written over APB.
	prog_line_t  prog_mem [PROG_LINES];
	logic        line_written [PROG_LINES];
	logic [15:0] stack_mem [STACK_WORDS];
	int          stack_level = 0;
	logic [15:0] acc_q = '0;
	logic [15:0] bak_q = '0;
	logic [3:0]  pc_q = '0;
	logic [4:0]  length_reg = 5'd1;

	// Set per burst: favours pushes over pops so that the stack really overflows.
	logic push_bias = 1'b0;

	initial begin
		for (int i = 0; i < PROG_LINES; i++) begin
			line_written[i] = 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Out-of-range lengths are clamped: zero behaves as one line, anything above the
	// depth of the program memory as the whole memory.
	function automatic int used_lines();
		if (length_reg == 0) return 1;
		if (length_reg > PROG_LINES) return PROG_LINES;
		return int'(length_reg);
	endfunction

	// Where a jump lands: negative targets are pulled back to line 0, and a target at
	// or past the end of the program wraps to line 0 as well.
	function automatic int landing_line(int target);
		if (target < 0 || target >= used_lines()) return 0;
		return target;
	endfunction

	// Applies one word to the private copy and returns the result word it must give.
	task automatic execute_word(input acn_word_t w, output result_t r);
		prog_line_t  ln;
		logic [15:0] val;
		logic        have;
		int          nxt;
		int          a;
		r = '0;
		if (w.opcode == OP_LOAD) begin
			ln.kind    = w.instr_kind;
			ln.source  = w.instr_source;
			ln.dest    = w.instr_dest;
			ln.operand = w.instr_operand;
			prog_mem[w.load_address]     = ln;
			line_written[w.load_address] = 1'b1;
			nxt = int'(pc_q);
		end else begin
			ln   = prog_mem[pc_q];
			have = 1'b0;
			val  = '0;
			nxt  = landing_line(int'(pc_q) + 1);

			// Only add, sub, mov and jro fetch an operand. A stack pop happens here,
			// before the instruction itself, whatever the instruction then does.
			if ((ln.kind >= KIND_ADD && ln.kind <= KIND_MOV) || ln.kind == KIND_JRO) begin
				case (ln.source)
					SRC_ACC: begin
						val  = acc_q;
						have = 1'b1;
					end
					SRC_INPUT: begin
						if (w.input_valid) begin
							val  = w.input_value;
							have = 1'b1;
							r.input_consumed = 1'b1;
						end else begin
							r.starved = 1'b1;
						end
					end
					SRC_IMM: begin
						val  = ln.operand;
						have = 1'b1;
					end
					SRC_STACK: begin
						if (stack_level > 0) begin
							stack_level--;
							val = stack_mem[stack_level];
						end else begin
							r.stack_empty_read = 1'b1;
						end
						have = 1'b1;
					end
					default: ;
				endcase
			end

			// A starved step skips the instruction; only the program counter moves on.
			if (!r.starved) begin
				a = int'($signed(acc_q));
				case (ln.kind)
					KIND_SWP: begin
						val   = acc_q;
						acc_q = bak_q;
						bak_q = val;
					end
					KIND_SAV: bak_q = acc_q;
					KIND_NEG: acc_q = -acc_q;
					KIND_ADD: if (have) acc_q = acc_q + val;
					KIND_SUB: if (have) acc_q = acc_q - val;
					KIND_MOV: begin
						case (ln.dest)
							DEST_ACC: acc_q = val;
							DEST_OUT: begin
								r.out_valid = 1'b1;
								r.out_value = val;
							end
							DEST_STACK: begin
								if (stack_level < STACK_WORDS) begin
									stack_mem[stack_level] = val;
									stack_level++;
								end else begin
									r.stack_dropped = 1'b1;
								end
							end
							default: ;
						endcase
					end
					KIND_JMP: nxt = landing_line(int'($signed(ln.operand)));
					KIND_JEZ: if (a == 0) nxt = landing_line(int'($signed(ln.operand)));
					KIND_JNZ: if (a != 0) nxt = landing_line(int'($signed(ln.operand)));
					KIND_JGZ: if (a > 0) nxt = landing_line(int'($signed(ln.operand)));
					KIND_JLZ: if (a < 0) nxt = landing_line(int'($signed(ln.operand)));
					KIND_JRO: begin
						// No usable source means offset zero: the PC stays, or wraps to 0 if past the end.
						nxt = landing_line(int'(pc_q) + (have ? int'($signed(val)) : 0));
					end
					default: ;
				endcase
			end
			pc_q = nxt[3:0];
		end
		r.next_pc   = nxt[3:0];
		r.acc_value = acc_q;
		r.bak_value = bak_q;
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Full-range data with the corner values drawn often.
	function automatic logic [15:0] random_data();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			4: return 16'h0001;
			default: return 16'($urandom);
		endcase
	endfunction

	// A random program line. Operands are often small so that jump targets and
	// relative offsets fall inside the program rather than always wrapping to 0.
	function automatic prog_line_t random_line();
		prog_line_t ln;
		int         roll;
		roll = $urandom_range(0, 99);
		if (roll < 4) ln.kind = 4'($urandom_range(13, 15));
		else if (roll < 34) ln.kind = KIND_MOV;
		else ln.kind = 4'($urandom_range(0, 12));

		roll = $urandom_range(0, 99);
		if (roll < 3) ln.source = 3'($urandom_range(5, 7));
		else if (roll < 8) ln.source = SRC_NONE;
		else if (roll < (push_bias ? 13 : 30)) ln.source = SRC_STACK;
		else ln.source = 3'($urandom_range(0, 2));

		if (push_bias && $urandom_range(0, 9) < 7) ln.dest = DEST_STACK;
		else ln.dest = 2'($urandom_range(0, 3));

		case ($urandom_range(0, 3))
			0: ln.operand = 16'($urandom_range(0, 18));
			1: ln.operand = -16'($urandom_range(1, 5));
			default: ln.operand = random_data();
		endcase
		return ln;
	endfunction

	function automatic prog_line_t mk_line(logic [3:0] kind, logic [2:0] source,
			logic [1:0] dest, logic [15:0] operand);
		prog_line_t ln;
		ln.kind    = kind;
		ln.source  = source;
		ln.dest    = dest;
		ln.operand = operand;
		return ln;
	endfunction

	// Predicts a word and queues it together with its expected result.
	task automatic issue_word(input acn_word_t w);
		result_t r;
		execute_word(w, r);
		pending_words.push_back(w);
		expected_results.push_back(r);
		issued++;
	endtask

	// Fields a word does not use are filled with random bits; the block must ignore them.
	function automatic acn_word_t junk_word();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return bits[$bits(acn_word_t)-1:0];
	endfunction

	task automatic issue_load(input logic [3:0] where, input prog_line_t ln);
		acn_word_t w;
		w = junk_word();
		w.opcode        = OP_LOAD;
		w.load_address  = where;
		w.instr_kind    = ln.kind;
		w.instr_source  = ln.source;
		w.instr_dest    = ln.dest;
		w.instr_operand = ln.operand;
		issue_word(w);
	endtask

	// A step never runs a line that has not been loaded: such a line is loaded first.
	task automatic issue_step(input logic ivalid, input logic [15:0] ival);
		acn_word_t w;
		if (!line_written[pc_q]) issue_load(pc_q, random_line());
		w = junk_word();
		w.opcode      = OP_STEP;
		w.input_valid = ivalid;
		w.input_value = ival;
		issue_word(w);
	endtask

	task automatic load_and_step(input prog_line_t ln, input logic ivalid,
			input logic [15:0] ival);
		issue_load(pc_q, ln);
		issue_step(ivalid, ival);
	endtask

	// A burst is a few loads, mostly near the program counter, followed by a run of
	// steps; bursts long enough to overflow the stack occur on short programs.
	task automatic random_burst();
		int         n_steps;
		logic [3:0] where;
		push_bias = ($urandom_range(0, 3) == 0);
		repeat ($urandom_range(0, 2)) begin
			if ($urandom_range(0, 1)) where = pc_q + 4'($urandom_range(0, 3));
			else where = 4'($urandom_range(0, 15));
			issue_load(where, random_line());
		end
		n_steps = $urandom_range(1, 20);
		repeat (n_steps) issue_step($urandom_range(0, 99) < 92, random_data());
	endtask

	task automatic random_phase(input int n_words);
		int goal;
		goal = issued + n_words;
		while (issued < goal) random_burst();
	endtask

	// Waits until every queued word has been taken and every result has come back.
	// Every word gives a result, so the extra cycles only let the pipeline settle.
	task automatic wait_drained();
		while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One APB write of program_length: a setup cycle, then the access cycle, which
	// completes at the edge where pready is seen high.
	task automatic write_length(input logic [4:0] value);
		wait_drained();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_PROGRAM_LENGTH, 2'b00};
		pwdata  <= {27'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		length_reg = value;
	endtask

	// ------------------------------------------------------------------
	// Driver, receiver and monitor
	// ------------------------------------------------------------------

	// A new word is put up only once the previous one has been taken, so valid never
	// drops while a word is on offer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_r <= 1'b0;
		end else if (!in_valid_r || in_ch.ready) begin
			if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= 24)) begin
				in_word_r  <= pending_words.pop_front();
				in_valid_r <= 1'b1;
			end else begin
				in_valid_r <= 1'b0;
			end
		end
	end

	// The long hold is timed here, independently of the stimulus.
	always @(posedge clk) begin
		if (!hold_req) begin
			hold_cnt <= 0;
		end else if (hold_cnt < HOLD_CYCLES) begin
			hold_cnt <= hold_cnt + 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready_r <= 1'b0;
		end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
			out_ready_r <= 1'b0;
		end else begin
			out_ready_r <= steady || $urandom_range(0, 99) >= 24;
		end
	end

	task automatic flag_mismatch(input string field, input logic [15:0] got,
			input logic [15:0] want);
		$display("result word %0d: %s is %h, predicted %h", results_seen, field, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_ch.valid && out_ready_r) begin
			if (expected_results.size() == 0) begin
				flag_mismatch("word with none predicted", 16'h0, 16'h0);
			end else begin
				want = expected_results.pop_front();
				if (out_ch.out_valid !== want.out_valid)
					flag_mismatch("out_valid", 16'(out_ch.out_valid), 16'(want.out_valid));
				if (out_ch.out_value !== want.out_value)
					flag_mismatch("out_value", out_ch.out_value, want.out_value);
				if (out_ch.input_consumed !== want.input_consumed)
					flag_mismatch("input_consumed", 16'(out_ch.input_consumed),
						16'(want.input_consumed));
				if (out_ch.starved !== want.starved)
					flag_mismatch("starved", 16'(out_ch.starved), 16'(want.starved));
				if (out_ch.stack_dropped !== want.stack_dropped)
					flag_mismatch("stack_dropped", 16'(out_ch.stack_dropped),
						16'(want.stack_dropped));
				if (out_ch.stack_empty_read !== want.stack_empty_read)
					flag_mismatch("stack_empty_read", 16'(out_ch.stack_empty_read),
						16'(want.stack_empty_read));
				if (out_ch.next_pc !== want.next_pc)
					flag_mismatch("next_pc", 16'(out_ch.next_pc), 16'(want.next_pc));
				if (out_ch.acc_value !== want.acc_value)
					flag_mismatch("acc_value", out_ch.acc_value, want.acc_value);
				if (out_ch.bak_value !== want.bak_value)
					flag_mismatch("bak_value", out_ch.bak_value, want.bak_value);
			end
			results_seen <= results_seen + 1;
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("accumulator_node_cpu verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the reset length of one line so that every step runs
		// line 0 and each load below sets up the very next step. The top line of
		// program memory is loaded once to exercise the highest address.
		issue_load(4'd15, mk_line(KIND_NOP, SRC_ACC, DEST_ACC, 16'h0000));
		// Largest positive value, then one more wraps to the most negative.
		load_and_step(mk_line(KIND_MOV, SRC_IMM, DEST_ACC, 16'h7FFF), 1'b0, 16'h0);
		load_and_step(mk_line(KIND_ADD, SRC_IMM, DEST_ACC, 16'h0001), 1'b1, 16'h1234);
		// Negating the most negative value leaves it unchanged.
		load_and_step(mk_line(KIND_NEG, SRC_NONE, DEST_NONE, 16'h0), 1'b1, 16'h0);
		load_and_step(mk_line(KIND_SAV, SRC_ACC, DEST_ACC, 16'h0), 1'b1, 16'h0);
		load_and_step(mk_line(KIND_SUB, SRC_INPUT, DEST_ACC, 16'h0), 1'b1, 16'h7FFF);
		load_and_step(mk_line(KIND_SWP, SRC_ACC, DEST_ACC, 16'h0), 1'b0, 16'h0);
		// Input needed but none offered: the step is starved.
		load_and_step(mk_line(KIND_MOV, SRC_INPUT, DEST_OUT, 16'h0), 1'b0, 16'hFFFF);
		load_and_step(mk_line(KIND_MOV, SRC_INPUT, DEST_OUT, 16'h0), 1'b1, 16'hFFFF);
		// One push and its pop, then a pop from the empty stack, which reads zero.
		load_and_step(mk_line(KIND_MOV, SRC_ACC, DEST_STACK, 16'h0), 1'b1, 16'h0);
		load_and_step(mk_line(KIND_ADD, SRC_STACK, DEST_ACC, 16'h0), 1'b1, 16'h0);
		load_and_step(mk_line(KIND_MOV, SRC_STACK, DEST_ACC, 16'h0), 1'b1, 16'h0);
		// An undefined instruction kind, and a mov from an undefined source.
		load_and_step(mk_line(KIND_BOGUS, SRC_IMM, DEST_OUT, 16'h8000), 1'b1, 16'h0);
		load_and_step(mk_line(KIND_MOV, SRC_BOGUS, DEST_OUT, 16'h5555), 1'b1, 16'h0);

		random_phase(30);

		// Full program memory, with the long receiver hold in the middle: the sender
		// keeps offering words until the block fills up and drops ready.
		write_length(5'd16);
		random_phase(40);
		@(posedge clk);
		hold_req <= 1'b1;
		random_phase(20);
		@(posedge clk);
		while (hold_cnt < HOLD_CYCLES) @(posedge clk);
		hold_req <= 1'b0;
		random_phase(20);

		// Shortening the program can leave the PC past the end; that line still runs.
		write_length(5'd5);
		random_phase(40);

		// Out-of-range lengths: zero acts as one line, 31 as the whole memory.
		write_length(5'd0);
		random_phase(20);
		write_length(5'd31);
		random_phase(20);

		// A stretch with no idling on either side.
		write_length(5'd9);
		@(posedge clk);
		steady <= 1'b1;
		random_phase(60);
		wait_drained();
		steady <= 1'b0;

		// The sender pauses mid-phase until every outstanding result is back.
		write_length(5'd16);
		random_phase(30);
		wait_drained();
		random_phase(30);

		write_length(5'd1);
		random_phase(20);

		wait_drained();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("accumulator_node_cpu verification clean");
		end else begin
			$display("accumulator_node_cpu verification failed");
		end
		$finish;
	end

endmodule
